// File: sv/ism_pkg.sv
package ism_pkg;

  localparam int unsigned NUM_SUBS_DEF  = 1024;
  localparam int unsigned NUM_ATTRS_DEF = 16;
  localparam int unsigned VALUE_DOMAIN  = 1024;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned SUB_W      = 10;
  localparam int unsigned ATTR_W     = 4;
  localparam int unsigned VAL_W      = 10;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned SKIP_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned Q_DEPTH    = 4;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PUB    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SUBS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_MASK   = 2'd1;

  localparam logic RES_MATCH  = 1'b0;
  localparam logic RES_DELETE = 1'b1;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SUB_W-1:0]  sub_id;
    logic [ATTR_W-1:0] attribute;
    logic [VAL_W-1:0]  low_bound;
    logic [VAL_W-1:0]  high_bound;
    logic [VAL_W-1:0]  event_value;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic             result_kind;
    logic [CNT_W-1:0] match_count;
    logic             delete_ok;
    logic [CNT_W-1:0] live_subs;
  } out_item_t;

  // classified item as held in the queue
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic              sub_ok;
    logic              attr_ok;
    logic [SUB_W-1:0]  sub_id;
    logic [ATTR_W-1:0] attribute;
    logic [VAL_W-1:0]  low_bound;
    logic [VAL_W-1:0]  high_bound;
    logic [VAL_W-1:0]  event_value;
    logic              last;
  } op_t;

  typedef struct packed {
    logic [CNT_W-1:0]  active_subs;
    logic [SKIP_W-1:0] skip_mask;
  } cfg_t;

endpackage

// File: sv/ism_front.sv
module ism_front #(
  parameter int unsigned NUM_SUBS  = ism_pkg::NUM_SUBS_DEF,
  parameter int unsigned NUM_ATTRS = ism_pkg::NUM_ATTRS_DEF
) (
  input  logic              in_valid,
  output logic              in_stall,
  input  ism_pkg::in_item_t in_item,
  input  logic              hold,
  input  logic              q_full,
  output logic              q_push,
  output ism_pkg::op_t      q_op
);

  localparam int unsigned VW     = ism_pkg::VAL_W;
  localparam int unsigned VTOP   = (1 << VW) - 1;
  localparam int unsigned VMAX_I = (ism_pkg::VALUE_DOMAIN - 1 > VTOP) ? VTOP
                                   : ism_pkg::VALUE_DOMAIN - 1;
  localparam logic [VW-1:0] VMAX = VW'(VMAX_I);

  function automatic logic [VW-1:0] clamp_val(input logic [VW-1:0] v);
    return (v > VMAX) ? VMAX : v;
  endfunction

  logic cmd_known;

  assign in_stall = hold | q_full;

  always_comb begin
    cmd_known = (in_item.command == ism_pkg::CMD_INSERT) ||
                (in_item.command == ism_pkg::CMD_DELETE) ||
                (in_item.command == ism_pkg::CMD_PUB);
    q_op.command     = in_item.command;
    q_op.sub_ok      = 32'(in_item.sub_id) < NUM_SUBS;
    q_op.attr_ok     = 32'(in_item.attribute) < NUM_ATTRS;
    q_op.sub_id      = in_item.sub_id;
    q_op.attribute   = in_item.attribute;
    q_op.low_bound   = clamp_val(in_item.low_bound);
    q_op.high_bound  = clamp_val(in_item.high_bound);
    q_op.event_value = clamp_val(in_item.event_value);
    q_op.last        = in_item.last;
  end

  // the unused command code is dropped here and never reaches the back end
  assign q_push = in_valid & ~in_stall & cmd_known;

endmodule

// File: sv/ism_fifo.sv
module ism_fifo (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  ism_pkg::op_t op_in,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output ism_pkg::op_t op_out
);

  localparam int unsigned QP_W = $clog2(ism_pkg::Q_DEPTH);

  ism_pkg::op_t    mem_r [ism_pkg::Q_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QP_W:0]   cnt_r, cnt_nxt;

  assign full   = cnt_r == (QP_W+1)'(ism_pkg::Q_DEPTH);
  assign empty  = cnt_r == '0;
  assign op_out = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= op_in;
    end
  end

endmodule

// File: sv/ism_back.sv
module ism_back #(
  parameter int unsigned NUM_SUBS  = ism_pkg::NUM_SUBS_DEF,
  parameter int unsigned NUM_ATTRS = ism_pkg::NUM_ATTRS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ism_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  ism_pkg::op_t       q_op,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_stall,
  output ism_pkg::out_item_t out_item
);

  localparam int unsigned SIDX_W     = $clog2(NUM_SUBS);
  localparam int unsigned AIDX_W     = (NUM_ATTRS > 1) ? $clog2(NUM_ATTRS) : 1;
  localparam int unsigned TA_W       = SIDX_W + AIDX_W;
  localparam int unsigned TDEPTH     = NUM_SUBS * (1 << AIDX_W);
  localparam int unsigned VW         = ism_pkg::VAL_W;
  localparam int unsigned BND_W      = 2 * VW;
  localparam int unsigned CW         = ism_pkg::CNT_W;
  localparam int unsigned CMP_W      = (SIDX_W > CW) ? SIDX_W : CW;
  localparam int unsigned CTOP       = (1 << CW) - 1;
  localparam int unsigned LIVE_MAX_I = (NUM_SUBS > CTOP) ? CTOP : NUM_SUBS;
  localparam logic [CW-1:0]     LIVE_MAX = CW'(LIVE_MAX_I);
  localparam logic [SIDX_W-1:0] SLAST    = SIDX_W'(NUM_SUBS - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RMW   = 6'b000100,
    S_SCAN  = 6'b001000,
    S_FINAL = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  ism_pkg::op_t       op_r, op_nxt;
  logic [SIDX_W-1:0]  scnt_r, scnt_nxt;
  logic               iss_r, iss_nxt;
  logic               p_vld_r, p_vld_nxt;
  logic [SIDX_W-1:0]  p_idx_r, p_idx_nxt;
  logic [NUM_ATTRS-1:0] present_r, present_nxt;
  logic [CW-1:0]      live_r, live_nxt;
  logic               dall_r, dall_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  ism_pkg::out_item_t res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  ism_pkg::out_item_t out_r;
  logic               out_load;

  // constraint store: bounds per (sub, attr), valid bits one row per sub
  logic [BND_W-1:0]     bnd_mem [TDEPTH];
  logic [BND_W-1:0]     bnd_q;
  logic [TA_W-1:0]      bnd_raddr, bnd_waddr;
  logic                 bnd_we;
  logic [BND_W-1:0]     bnd_wdata;
  logic [NUM_ATTRS-1:0] vld_mem [NUM_SUBS];
  logic [NUM_ATTRS-1:0] vld_q;
  logic [SIDX_W-1:0]    vld_raddr, vld_waddr;
  logic                 vld_we;
  logic [NUM_ATTRS-1:0] vld_wdata;
  logic                 mark_mem [NUM_SUBS];
  logic                 mark_q;
  logic [SIDX_W-1:0]    mark_raddr, mark_waddr;
  logic                 mark_we;
  logic                 mark_wdata;

  logic [SIDX_W-1:0]    head_sidx, op_sidx;
  logic [AIDX_W-1:0]    head_aidx, op_aidx;
  logic [NUM_ATTRS-1:0] miss;
  logic                 found, del_ok, excl, marked, in_range;
  logic [CW-1:0]        live_dec;
  logic [VW-1:0]        bnd_lo, bnd_hi;

  assign head_sidx = SIDX_W'(q_op.sub_id);
  assign head_aidx = AIDX_W'(q_op.attribute);
  assign op_sidx   = SIDX_W'(op_r.sub_id);
  assign op_aidx   = AIDX_W'(op_r.attribute);
  assign in_range  = op_r.sub_ok & op_r.attr_ok;
  assign bnd_lo    = bnd_q[BND_W-1:VW];
  assign bnd_hi    = bnd_q[VW-1:0];

  // attributes that are neither in the publication nor skipped
  always_comb begin
    for (int a = 0; a < NUM_ATTRS; a++) begin
      if (a < ism_pkg::SKIP_W) begin
        miss[a] = ~present_r[a] & ~cfg.skip_mask[a[ism_pkg::ATTR_W-1:0]];
      end else begin
        miss[a] = ~present_r[a];
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    scnt_nxt    = scnt_r;
    iss_nxt     = iss_r;
    p_vld_nxt   = 1'b0;
    p_idx_nxt   = p_idx_r;
    present_nxt = present_r;
    live_nxt    = live_r;
    dall_nxt    = dall_r;
    cnt_nxt     = cnt_r;
    res_nxt     = res_r;
    q_pop       = 1'b0;
    out_load    = 1'b0;

    vld_raddr  = scnt_r;
    vld_we     = 1'b0;
    vld_waddr  = op_sidx;
    vld_wdata  = vld_q;
    bnd_raddr  = {scnt_r, op_aidx};
    bnd_we     = 1'b0;
    bnd_waddr  = {op_sidx, op_aidx};
    bnd_wdata  = {op_r.low_bound, op_r.high_bound};
    mark_raddr = scnt_r;
    mark_we    = 1'b0;
    mark_waddr = p_idx_r;
    mark_wdata = 1'b0;

    found    = in_range & vld_q[op_aidx];
    del_ok   = dall_r & found;
    live_dec = (del_ok && live_r != '0) ? live_r - 1'b1 : live_r;
    excl     = vld_q[op_aidx] & ((bnd_lo > op_r.event_value) |
                                 (bnd_hi < op_r.event_value));
    marked   = mark_q | (|(vld_q & miss));

    unique case (state_r)
      S_CLEAR: begin
        vld_waddr  = scnt_r;
        vld_wdata  = '0;
        vld_we     = 1'b1;
        mark_waddr = scnt_r;
        mark_we    = 1'b1;
        if (scnt_r == SLAST) begin
          scnt_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          scnt_nxt = scnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          op_nxt    = q_op;
          vld_raddr = head_sidx;
          if (q_op.command == ism_pkg::CMD_PUB) begin
            if (q_op.attr_ok) begin
              present_nxt[head_aidx] = 1'b1;
            end
            if (q_op.attr_ok && !cfg.skip_mask[q_op.attribute]) begin
              scnt_nxt  = '0;
              iss_nxt   = 1'b1;
              state_nxt = S_SCAN;
            end else if (q_op.last) begin
              scnt_nxt  = '0;
              iss_nxt   = 1'b1;
              cnt_nxt   = '0;
              state_nxt = S_FINAL;
            end
          end else begin
            state_nxt = S_RMW;
          end
        end
      end
      S_RMW: begin
        if (op_r.command == ism_pkg::CMD_INSERT) begin
          if (in_range) begin
            bnd_we             = 1'b1;
            vld_we             = 1'b1;
            vld_wdata[op_aidx] = 1'b1;
          end
          if (op_r.last && live_r < LIVE_MAX) begin
            live_nxt = live_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end else begin
          if (found) begin
            vld_we             = 1'b1;
            vld_wdata[op_aidx] = 1'b0;
          end
          if (op_r.last) begin
            live_nxt            = live_dec;
            dall_nxt            = 1'b1;
            res_nxt.result_kind = ism_pkg::RES_DELETE;
            res_nxt.match_count = '0;
            res_nxt.delete_ok   = del_ok;
            res_nxt.live_subs   = live_dec;
            state_nxt           = S_OUT;
          end else begin
            dall_nxt  = del_ok;
            state_nxt = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        if (iss_r) begin
          p_vld_nxt = 1'b1;
          p_idx_nxt = scnt_r;
          if (scnt_r == SLAST) begin
            iss_nxt = 1'b0;
          end else begin
            scnt_nxt = scnt_r + 1'b1;
          end
        end
        if (p_vld_r) begin
          mark_we    = excl;
          mark_wdata = 1'b1;
        end
        if (!iss_r && !p_vld_r) begin
          if (op_r.last) begin
            scnt_nxt  = '0;
            iss_nxt   = 1'b1;
            cnt_nxt   = '0;
            state_nxt = S_FINAL;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FINAL: begin
        if (iss_r) begin
          p_vld_nxt = 1'b1;
          p_idx_nxt = scnt_r;
          if (scnt_r == SLAST) begin
            iss_nxt = 1'b0;
          end else begin
            scnt_nxt = scnt_r + 1'b1;
          end
        end
        // count and wipe the mark in the same pass
        if (p_vld_r) begin
          mark_we = 1'b1;
          if (!marked && CMP_W'(p_idx_r) < CMP_W'(cfg.active_subs) &&
              cnt_r != ism_pkg::COUNT_MAX) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        if (!iss_r && !p_vld_r) begin
          present_nxt         = '0;
          res_nxt.result_kind = ism_pkg::RES_MATCH;
          res_nxt.match_count = cnt_r;
          res_nxt.delete_ok   = 1'b0;
          res_nxt.live_subs   = live_r;
          state_nxt           = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      scnt_r      <= '0;
      iss_r       <= 1'b0;
      p_vld_r     <= 1'b0;
      present_r   <= '0;
      live_r      <= '0;
      dall_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scnt_r      <= scnt_nxt;
      iss_r       <= iss_nxt;
      p_vld_r     <= p_vld_nxt;
      present_r   <= present_nxt;
      live_r      <= live_nxt;
      dall_r      <= dall_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    p_idx_r <= p_idx_nxt;
    cnt_r   <= cnt_nxt;
    res_r   <= res_nxt;
    if (out_load) begin
      out_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (bnd_we) begin
      bnd_mem[bnd_waddr] <= bnd_wdata;
    end
    bnd_q <= bnd_mem[bnd_raddr];
  end

  always_ff @(posedge clk) begin
    if (vld_we) begin
      vld_mem[vld_waddr] <= vld_wdata;
    end
    vld_q <= vld_mem[vld_raddr];
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    mark_q <= mark_mem[mark_raddr];
  end

  assign clearing  = state_r == S_CLEAR;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= LIVE_MAX)
    else $error("live count above its limit");

  a_stage_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> (state_r == S_SCAN || state_r == S_FINAL))
    else $error("read stage busy outside a scan");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.result_kind == ism_pkg::RES_MATCH) |->
      (out_r.match_count <= cfg.active_subs))
    else $error("match count above active subscriptions");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE && !iss_r && !p_vld_r))
    else $error("item taken while a pass was running");

  a_no_result_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_valid_r)
    else $error("result shown during clearing pass");

endmodule

// File: sv/interval_subscription_matcher_core.sv
// channel  dir  handshake              payload
// in_      in   in_valid / in_stall    in_item  (command, sub_id, attribute, bounds, value, last)
// out_     out  out_valid / out_stall  out_item (result_kind, match_count, delete_ok, live_subs)
// cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Insert and delete read the valid row in the back end and then write it back; the last
// delete item of a subscription also produces a result.
// A publication pair whose attribute is in range and not skipped sweeps one subscription row
// a cycle; the last pair also sweeps once more for missing attributes and the count.
// After reset a clearing pass wipes every valid row and mark; in_stall is
// high meanwhile. Configuration writes are taken in any cycle.
// A four-item queue decouples intake from execution; results wait in an output register.
module interval_subscription_matcher_core #(
  parameter int unsigned NUM_SUBS  = ism_pkg::NUM_SUBS_DEF,
  parameter int unsigned NUM_ATTRS = ism_pkg::NUM_ATTRS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ism_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ism_pkg::out_item_t              out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ism_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ism_pkg::CFG_DATA_W-1:0]  cfg_data
);

  ism_pkg::cfg_t cfg_r;
  ism_pkg::op_t  push_op, head_op;
  logic          q_push, q_pop, q_full, q_empty, clearing;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ism_pkg::REG_ACTIVE_SUBS: cfg_r.active_subs <= cfg_data[ism_pkg::CNT_W-1:0];
        ism_pkg::REG_SKIP_MASK:   cfg_r.skip_mask   <= cfg_data[ism_pkg::SKIP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ism_front #(
    .NUM_SUBS  (NUM_SUBS),
    .NUM_ATTRS (NUM_ATTRS)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .hold     (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_op     (push_op)
  );

  ism_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .op_in  (push_op),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .op_out (head_op)
  );

  ism_back #(
    .NUM_SUBS  (NUM_SUBS),
    .NUM_ATTRS (NUM_ATTRS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_op      (head_op),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// File: sim/interval_subscription_matcher_core_test.sv
`timescale 1ns / 1ps

module interval_subscription_matcher_core_test;
  import ism_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned ROWS = NUM_SUBS_DEF * NUM_ATTRS_DEF;
  // a full queue plus two more items, each a worst-case last pair
  localparam int unsigned SETTLE_CYCLES = (Q_DEPTH + 2) * (2 * NUM_SUBS_DEF + 8);

  typedef enum int {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow of the constraint table and publication state
  logic [VAL_W-1:0]        shadow_low [ROWS];
  logic [VAL_W-1:0]        shadow_high [ROWS];
  bit                      shadow_valid [ROWS];
  bit [NUM_SUBS_DEF-1:0]   excluded;
  bit [NUM_ATTRS_DEF-1:0]  seen_attrs;
  bit [CNT_W-1:0]          live_total;
  bit                      every_found = 1'b1;
  bit [CNT_W-1:0]          cfg_active;
  bit [SKIP_W-1:0]         cfg_skip;

  out_item_t   awaited_outcomes[$];
  out_item_t   want_res;
  int unsigned fail_count, n_inserts, n_deletes, n_pairs, n_results, n_writes;
  int unsigned traffic_sent, burst_left, stall_left, cyc;
  stall_mode_t stall_mode = STALL_NONE;

  interval_subscription_matcher_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    #400_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic bit table_step(input in_item_t it, output out_item_t res);
    int unsigned row;
    int unsigned lim;
    int unsigned count;
    bit          produced;
    row = 32'({it.sub_id, it.attribute});
    res = '0;
    produced = 1'b0;
    case (it.command)
      CMD_INSERT: begin
        shadow_low[row] = it.low_bound;
        shadow_high[row] = it.high_bound;
        shadow_valid[row] = 1'b1;
        if (it.last && live_total < NUM_SUBS_DEF) live_total++;
      end
      CMD_DELETE: begin
        if (shadow_valid[row]) shadow_valid[row] = 1'b0;
        else every_found = 1'b0;
        if (it.last) begin
          if (every_found && live_total != 0) live_total--;
          res.result_kind = RES_DELETE;
          res.delete_ok = every_found;
          res.live_subs = live_total;
          every_found = 1'b1;
          produced = 1'b1;
        end
      end
      CMD_PUB: begin
        seen_attrs[it.attribute] = 1'b1;
        if (!cfg_skip[it.attribute]) begin
          for (int s = 0; s < NUM_SUBS_DEF; s++) begin
            row = s * NUM_ATTRS_DEF + it.attribute;
            if (shadow_valid[row] && (shadow_low[row] > it.event_value ||
                                      shadow_high[row] < it.event_value))
              excluded[s] = 1'b1;
          end
        end
        if (it.last) begin
          // constrained attributes absent from the publication and not skipped
          for (int a = 0; a < NUM_ATTRS_DEF; a++) begin
            if (!seen_attrs[a] && !cfg_skip[a]) begin
              for (int s = 0; s < NUM_SUBS_DEF; s++)
                if (shadow_valid[s * NUM_ATTRS_DEF + a]) excluded[s] = 1'b1;
            end
          end
          lim = (cfg_active > NUM_SUBS_DEF) ? NUM_SUBS_DEF : cfg_active;
          count = 0;
          for (int s = 0; s < lim; s++)
            if (!excluded[s]) count++;
          excluded = '0;
          seen_attrs = '0;
          res.result_kind = RES_MATCH;
          res.match_count = count[CNT_W-1:0];
          res.live_subs = live_total;
          produced = 1'b1;
        end
      end
      default: ;
    endcase
    return produced;
  endfunction

  function automatic in_item_t make_item(input logic [CMD_W-1:0] cmd, input int unsigned sub,
                                         input int unsigned attr, input int unsigned lo,
                                         input int unsigned hi, input int unsigned val,
                                         input bit last);
    in_item_t it;
    it.command = cmd;
    it.sub_id = sub[SUB_W-1:0];
    it.attribute = attr[ATTR_W-1:0];
    it.low_bound = lo[VAL_W-1:0];
    it.high_bound = hi[VAL_W-1:0];
    it.event_value = val[VAL_W-1:0];
    it.last = last;
    return it;
  endfunction

  function automatic int unsigned pick_sub();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, NUM_SUBS_DEF - 1)
                                       : $urandom_range(0, 47);
  endfunction

  function automatic int unsigned pick_attr();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, NUM_ATTRS_DEF - 1)
                                       : $urandom_range(0, 5);
  endfunction

  function automatic int unsigned pick_value();
    if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) == 0) ? 0 : VALUE_DOMAIN - 1;
    return $urandom_range(0, VALUE_DOMAIN - 1);
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns  %s: got %0d, expected %0d", $time, field, got, want);
    fail_count++;
  endtask

  // bursts of random length, gaps between them; occasionally a long one
  task automatic send_item(input in_item_t it);
    out_item_t   res;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) == 0) gap = 0;
      else if ($urandom_range(0, 9) == 0) gap = $urandom_range(200, 2500);
      else gap = $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_item = it;
    do @(posedge clk); while (in_stall);
    if (table_step(it, res)) awaited_outcomes.insert(awaited_outcomes.size(), res);
    case (it.command)
      CMD_INSERT: n_inserts++;
      CMD_DELETE: n_deletes++;
      CMD_PUB:    n_pairs++;
      default: ;
    endcase
    if (it.command != CMD_UNUSED) traffic_sent++;
  endtask

  // sender pauses until every result is in, then lets the back end go quiet
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ACTIVE_SUBS) cfg_active = data[CNT_W-1:0];
    else if (idx == REG_SKIP_MASK) cfg_skip = data[SKIP_W-1:0];
    n_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic subscribe(input int unsigned sub);
    int unsigned k, lo, hi;
    k = $urandom_range(1, 3);
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        lo = pick_value();
        hi = pick_value();
      end else begin
        lo = $urandom_range(0, 600);
        hi = $urandom_range(lo, VALUE_DOMAIN - 1);
      end
      send_item(make_item(CMD_INSERT, sub, pick_attr(), lo, hi, $urandom, i == k - 1));
    end
  endtask

  task automatic publish();
    int unsigned k, base, attr;
    k = $urandom_range(1, 6);
    base = $urandom_range(0, 5);
    for (int i = 0; i < k; i++) begin
      attr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, NUM_ATTRS_DEF - 1) : (base + i) % 6;
      send_item(make_item(CMD_PUB, $urandom, attr, $urandom, $urandom, pick_value(),
                          i == k - 1));
      // table changes in the middle of a publication
      if (i != k - 1 && $urandom_range(0, 11) == 0) subscribe(pick_sub());
    end
  endtask

  task automatic unsubscribe(input int unsigned sub);
    int unsigned held[$];
    int unsigned k;
    for (int a = 0; a < NUM_ATTRS_DEF; a++)
      if (shadow_valid[sub * NUM_ATTRS_DEF + a]) held.insert(held.size(), a);
    if (held.size() == 0 || $urandom_range(0, 3) == 0) begin
      k = $urandom_range(1, 3);
      for (int i = 0; i < k; i++)
        send_item(make_item(CMD_DELETE, sub, pick_attr(), $urandom, $urandom, $urandom,
                            i == k - 1));
    end else begin
      for (int i = 0; i < held.size(); i++)
        send_item(make_item(CMD_DELETE, sub, held[i], $urandom, $urandom, $urandom,
                            i == held.size() - 1));
    end
  endtask

  task automatic random_traffic(input int unsigned n);
    int unsigned start, roll;
    start = traffic_sent;
    while (traffic_sent - start < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) subscribe(pick_sub());
      else if (roll < 70) publish();
      else if (roll < 90) unsubscribe(pick_sub());
      else send_item(make_item(CMD_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom_range(0, 1) == 1));
    end
  endtask

  task automatic test_empty_table();
    write_reg(REG_ACTIVE_SUBS, CFG_DATA_W'(NUM_SUBS_DEF));
    write_reg(REG_SKIP_MASK, '0);
    send_item(make_item(CMD_PUB, 0, 0, 0, 0, 0, 1'b1));
    send_item(make_item(CMD_UNUSED, '1, '1, '1, '1, '1, 1'b1));
    settle();
    write_reg(REG_ACTIVE_SUBS, CFG_DATA_W'(0));
    send_item(make_item(CMD_PUB, 0, 0, 0, 0, 0, 1'b1));
    settle();
    // beyond the table: counting stops at the last subscription
    write_reg(REG_ACTIVE_SUBS, CFG_DATA_W'(1500));
    send_item(make_item(CMD_PUB, 0, 0, 0, 0, VALUE_DOMAIN - 1, 1'b1));
    settle();
  endtask

  task automatic test_constraints();
    write_reg(REG_ACTIVE_SUBS, CFG_DATA_W'(NUM_SUBS_DEF));
    send_item(make_item(CMD_INSERT, 0, 0, 0, VALUE_DOMAIN - 1, 0, 1'b1));
    send_item(make_item(CMD_INSERT, NUM_SUBS_DEF - 1, 15, 1023, 1023, 0, 1'b0));
    send_item(make_item(CMD_INSERT, NUM_SUBS_DEF - 1, 0, 0, 0, 0, 1'b1));
    send_item(make_item(CMD_INSERT, 2, 7, 512, 100, 0, 1'b1));  // empty interval
    send_item(make_item(CMD_PUB, 0, 0, 0, 0, 0, 1'b0));
    send_item(make_item(CMD_PUB, 0, 15, 0, 0, 1023, 1'b1));
    send_item(make_item(CMD_PUB, 0, 0, 0, 0, 1023, 1'b1));
    send_item(make_item(CMD_PUB, 0, 7, 0, 0, 300, 1'b1));
    send_item(make_item(CMD_DELETE, 2, 7, 0, 0, 0, 1'b1));
    send_item(make_item(CMD_DELETE, 2, 7, 0, 0, 0, 1'b1));      // already gone
    send_item(make_item(CMD_DELETE, NUM_SUBS_DEF - 1, 15, 0, 0, 0, 1'b0));
    send_item(make_item(CMD_DELETE, NUM_SUBS_DEF - 1, 0, 0, 0, 0, 1'b1));
    send_item(make_item(CMD_DELETE, 0, 3, 0, 0, 0, 1'b0));      // never inserted
    send_item(make_item(CMD_DELETE, 0, 0, 0, 0, 0, 1'b1));
    send_item(make_item(CMD_INSERT, 6, 2, 1, 2, 0, 1'b0));
    send_item(make_item(CMD_DELETE, 6, 2, 0, 0, 0, 1'b1));
    // live count already zero: a good delete leaves it there
    send_item(make_item(CMD_INSERT, 5, 1, 3, 4, 0, 1'b0));
    send_item(make_item(CMD_DELETE, 5, 1, 0, 0, 0, 1'b1));
    settle();
  endtask

  task automatic test_skip_mask();
    send_item(make_item(CMD_INSERT, 3, 2, 10, 20, 0, 1'b1));
    settle();
    write_reg(REG_SKIP_MASK, 16'h0004);
    send_item(make_item(CMD_PUB, 0, 2, 0, 0, 500, 1'b1));
    send_item(make_item(CMD_PUB, 0, 9, 0, 0, 7, 1'b1));
    settle();
    write_reg(REG_SKIP_MASK, 16'hFFFF);
    send_item(make_item(CMD_PUB, 0, 2, 0, 0, 500, 1'b1));
    settle();
    write_reg(REG_SKIP_MASK, 16'h0000);
    send_item(make_item(CMD_PUB, 0, 2, 0, 0, 500, 1'b1));
    send_item(make_item(CMD_DELETE, 3, 2, 0, 0, 0, 1'b1));
    settle();
  endtask

  task automatic test_random_settings();
    int unsigned act [7];
    int unsigned skip [7];
    int unsigned budget [7];
    act = '{1024, 48, 0, 1024, 1500, 0, 32};
    skip = '{16'h0000, 16'h0001, 16'hFFFF, 16'hFFFF, 16'h0030, 0, 16'h0000};
    budget = '{140, 100, 30, 30, 80, 100, 100};
    act[5] = $urandom_range(0, NUM_SUBS_DEF);
    skip[5] = $urandom_range(0, 16'hFFFF);
    for (int p = 0; p < 7; p++) begin
      settle();
      write_reg(REG_ACTIVE_SUBS, CFG_DATA_W'(act[p]));
      write_reg(REG_SKIP_MASK, CFG_DATA_W'(skip[p]));
      random_traffic(budget[p]);
    end
  endtask

  // receiver stall pattern, independent of the sender
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(8, 600);
    end
    stall_left--;
    cyc++;
    case (stall_mode)
      STALL_NONE:     out_stall = 1'b0;
      STALL_COIN:     out_stall = ($urandom_range(0, 1) == 1);
      STALL_PERIODIC: out_stall = (cyc % 7) < 4;
      default:        out_stall = ($urandom_range(0, 9) < 8);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (awaited_outcomes.size() == 0) begin
        report_mismatch("result with nothing awaited, live_subs", 32'(out_item.live_subs), 0);
      end else begin
        want_res = awaited_outcomes.pop_front();
        if (out_item.result_kind !== want_res.result_kind)
          report_mismatch("result_kind", 32'(out_item.result_kind),
                          32'(want_res.result_kind));
        if (out_item.match_count !== want_res.match_count)
          report_mismatch("match_count", 32'(out_item.match_count),
                          32'(want_res.match_count));
        if (out_item.delete_ok !== want_res.delete_ok)
          report_mismatch("delete_ok", 32'(out_item.delete_ok), 32'(want_res.delete_ok));
        if (out_item.live_subs !== want_res.live_subs)
          report_mismatch("live_subs", 32'(out_item.live_subs), 32'(want_res.live_subs));
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_empty_table();
    test_constraints();
    test_skip_mask();
    test_random_settings();
    settle();
    $display("Sent %0d inserts, %0d deletes and %0d publication pairs; %0d register writes",
             n_inserts, n_deletes, n_pairs, n_writes);
    $display("Checked %0d results, %0d mismatches", n_results, fail_count);
    if (fail_count == 0 && awaited_outcomes.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
